// File: hw/rtl/trace_peak_normalizer_macros.svh
// assertion macros used by the normalizer top level
`ifndef TRACE_PEAK_NORMALIZER_MACROS_SVH
`define TRACE_PEAK_NORMALIZER_MACROS_SVH

// same-cycle implication
`define TPN_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tpn assertion failed");

// next-cycle implication
`define TPN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tpn assertion failed");

`endif

// File: hw/rtl/tpn_pkg.sv
// shared types and constants of the trace peak normalizer
package tpn_pkg;
   localparam int SAMPLE_BITS = 16;
   localparam int MAX_TRACE = 64;
   localparam int ADDR_BITS = $clog2(MAX_TRACE);
   localparam int LEN_BITS = 7;
   localparam int FULL_SCALE = 2 ** (SAMPLE_BITS - 1) - 1;
   localparam int PROD_BITS = 2 * SAMPLE_BITS;
   localparam int QUOT_BITS = 2 * SAMPLE_BITS - 1;
   localparam int GAIN_BITS = 16;

   localparam logic [1:0] REG_MODE = 2'd0;
   localparam logic [1:0] REG_LENGTH = 2'd1;
   localparam logic [1:0] REG_GAIN = 2'd2;
   localparam logic [1:0] REG_COMPLEX = 2'd3;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic normalize;
      logic complex_data;
      logic [LEN_BITS-1:0] eff_len;
      logic signed [GAIN_BITS-1:0] gain;
   } cfg_type;

   typedef enum logic {
      JOB_GAIN = 1'b0,
      JOB_TRACE = 1'b1
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      sample_type re;
      sample_type im;
      logic [SAMPLE_BITS-1:0] peak;
      logic [LEN_BITS-1:0] count;
   } job_type;
endpackage

// File: hw/rtl/tpn_ram.sv
// generic single-port-write, registered-read ram
module tpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/tpn_job_queue.sv
// short job queue between front and back
module tpn_job_queue
   import tpn_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  job_type job_in,
   input  logic pop,
   output job_type job_out,
   output logic empty,
   output logic full
);
   localparam int DEPTH = 4;
   localparam int PTR_BITS = $clog2(DEPTH);

   job_type entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0] count_ff, count_in;
   logic do_push, do_pop;

   assign empty = (count_ff == '0);
   assign full = (count_ff == (PTR_BITS+1)'(DEPTH));
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign job_out = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= job_in;
      end
   end
endmodule

// File: hw/rtl/tpn_front.sv
// front end: accepts words, stores traces, tracks the peak, issues jobs
module tpn_front
   import tpn_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  cfg_type cfg,
   input  logic cfg_clear,
   input  logic push,
   output logic full,
   input  sample_type sample_real,
   input  sample_type sample_imag,
   input  logic q_full,
   input  logic trace_busy,
   output logic q_push,
   output job_type q_job,
   output logic wr_en,
   output logic [ADDR_BITS-1:0] wr_addr,
   output logic [2*SAMPLE_BITS-1:0] wr_data
);
   typedef enum logic [4:0] {
      F_IDLE   = 5'b00001,
      F_SQUARE = 5'b00010,
      F_SUM    = 5'b00100,
      F_ROOT   = 5'b01000,
      F_DONE   = 5'b10000
   } front_state_type;

   localparam int ROOT_CNT_BITS = $clog2(SAMPLE_BITS);

   front_state_type state_ff, state_in;
   logic [LEN_BITS-1:0] fill_ff, fill_in;
   logic [SAMPLE_BITS-1:0] peak_ff, peak_in, mag_ff, mag_in;
   sample_type re_ff, im_ff, im_kept;
   logic signed [PROD_BITS-1:0] sq_re_ff, sq_im_ff, sq_re_in, sq_im_in;
   logic [PROD_BITS-1:0] rad_ff, rad_in;
   logic [SAMPLE_BITS-1:0] root_ff, root_in;
   logic [SAMPLE_BITS:0] rem_ff, rem_in;
   logic [SAMPLE_BITS+2:0] rem_shift, trial, rem_diff;
   logic [ROOT_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic accept, last;
   logic [LEN_BITS-1:0] fill_next;

   assign full = (state_ff != F_IDLE) || q_full || trace_busy;
   assign accept = push && !full;
   assign im_kept = cfg.complex_data ? sample_imag : '0;
   assign fill_next = fill_ff + 1'b1;
   assign last = (fill_next == cfg.eff_len);

   assign wr_en = accept && cfg.normalize;
   assign wr_addr = fill_ff[ADDR_BITS-1:0];
   assign wr_data = {sample_real, im_kept};

   // one root bit per cycle
   assign rem_shift = {rem_ff, rad_ff[PROD_BITS-1 -: 2]};
   assign trial = {1'b0, root_ff, 2'b01};
   assign rem_diff = rem_shift - trial;

   assign sq_re_in = PROD_BITS'(re_ff) * PROD_BITS'(re_ff);
   assign sq_im_in = PROD_BITS'(im_ff) * PROD_BITS'(im_ff);

   always_comb begin
      q_push = 1'b0;
      q_job.kind = JOB_GAIN;
      q_job.re = sample_real;
      q_job.im = im_kept;
      q_job.peak = (mag_ff > peak_ff) ? mag_ff : peak_ff;
      q_job.count = cfg.eff_len;
      state_in = state_ff;
      fill_in = fill_ff;
      peak_in = peak_ff;
      mag_in = mag_ff;
      rad_in = rad_ff;
      root_in = root_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               if (!cfg.normalize) begin
                  q_push = 1'b1;
               end else if (cfg.complex_data) begin
                  state_in = F_SQUARE;
               end else begin
                  mag_in = sample_real[SAMPLE_BITS-1] ?
                     SAMPLE_BITS'(-sample_real) : sample_real;
                  state_in = F_DONE;
               end
            end
         end
         F_SQUARE: state_in = F_SUM;
         F_SUM: begin
            rad_in = unsigned'(sq_re_ff) + unsigned'(sq_im_ff);
            root_in = '0;
            rem_in = '0;
            cnt_in = '0;
            state_in = F_ROOT;
         end
         F_ROOT: begin
            if (rem_shift >= trial) begin
               rem_in = rem_diff[SAMPLE_BITS:0];
               root_in = {root_ff[SAMPLE_BITS-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[SAMPLE_BITS:0];
               root_in = {root_ff[SAMPLE_BITS-2:0], 1'b0};
            end
            rad_in = {rad_ff[PROD_BITS-3:0], 2'b00};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ROOT_CNT_BITS'(SAMPLE_BITS - 1)) begin
               mag_in = root_in;
               state_in = F_DONE;
            end
         end
         F_DONE: begin
            if (!last) begin
               fill_in = fill_next;
               peak_in = q_job.peak;
               state_in = F_IDLE;
            end else if (!q_full) begin
               q_push = 1'b1;
               q_job.kind = JOB_TRACE;
               fill_in = '0;
               peak_in = '0;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
      if (cfg_clear) begin
         fill_in = '0;
         peak_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         fill_ff <= '0;
         peak_ff <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         peak_ff <= peak_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         re_ff <= sample_real;
         im_ff <= im_kept;
      end
      sq_re_ff <= sq_re_in;
      sq_im_ff <= sq_im_in;
      mag_ff <= mag_in;
      rad_ff <= rad_in;
      root_ff <= root_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end
endmodule

// File: hw/rtl/tpn_back.sv
// back end: runs gain and trace jobs and holds the result word
module tpn_back
   import tpn_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  cfg_type cfg,
   input  logic q_empty,
   input  job_type q_job,
   output logic q_pop,
   output logic [ADDR_BITS-1:0] rd_addr,
   input  logic [2*SAMPLE_BITS-1:0] rd_data,
   output logic trace_done,
   input  logic pop,
   output logic empty,
   output sample_type out_real,
   output sample_type out_imag,
   output logic end_of_trace
);
   typedef enum logic [5:0] {
      B_IDLE   = 6'b000001,
      B_GAIN   = 6'b000010,
      B_READ   = 6'b000100,
      B_SCALE  = 6'b001000,
      B_DIVIDE = 6'b010000,
      B_EMIT   = 6'b100000
   } back_state_type;

   localparam int DIV_CNT_BITS = $clog2(QUOT_BITS);
   localparam int SHIFT = 8;
   localparam logic signed [PROD_BITS-1:0] SAT_HI = PROD_BITS'(FULL_SCALE);
   localparam logic signed [PROD_BITS-1:0] SAT_LO = PROD_BITS'(-FULL_SCALE - 1);

   back_state_type state_ff, state_in;
   job_type job_ff;
   logic [LEN_BITS-1:0] idx_ff, idx_in;
   logic signed [PROD_BITS-1:0] gp_re_ff, gp_im_ff;
   logic [QUOT_BITS-1:0] num_re_ff, num_im_ff, num_re_in, num_im_in;
   logic [SAMPLE_BITS-1:0] rem_re_ff, rem_im_ff, rem_re_in, rem_im_in;
   logic neg_re_ff, neg_im_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic valid_ff, valid_in, load;
   sample_type out_re_ff, out_im_ff, res_re, res_im, rd_re, rd_im;
   logic eot_ff, res_eot, idx_last;
   logic [SAMPLE_BITS-1:0] abs_re, abs_im;
   logic [LEN_BITS-1:0] idx_next;

   function automatic sample_type sat_shift(input logic signed [PROD_BITS-1:0] p);
      logic signed [PROD_BITS-1:0] s;
      s = p >>> SHIFT;
      if (s > SAT_HI) return SAMPLE_BITS'(SAT_HI);
      if (s < SAT_LO) return SAMPLE_BITS'(SAT_LO);
      return SAMPLE_BITS'(s);
   endfunction

   function automatic sample_type sat_quot(input logic [QUOT_BITS-1:0] q, input logic neg);
      logic [QUOT_BITS-1:0] lim;
      lim = neg ? QUOT_BITS'(FULL_SCALE + 1) : QUOT_BITS'(FULL_SCALE);
      if (q > lim) q = lim;
      return neg ? SAMPLE_BITS'(-q) : SAMPLE_BITS'(q);
   endfunction

   // restoring division, one quotient bit per cycle
   function automatic logic [SAMPLE_BITS+QUOT_BITS-1:0] div_step(
      input logic [SAMPLE_BITS-1:0] rem, input logic [QUOT_BITS-1:0] num,
      input logic [SAMPLE_BITS-1:0] den);
      logic [SAMPLE_BITS:0] r;
      logic [SAMPLE_BITS:0] d;
      logic ge;
      r = {rem, num[QUOT_BITS-1]};
      d = r - {1'b0, den};
      ge = (r >= {1'b0, den});
      return {ge ? d[SAMPLE_BITS-1:0] : r[SAMPLE_BITS-1:0], num[QUOT_BITS-2:0], ge};
   endfunction

   assign rd_addr = idx_ff[ADDR_BITS-1:0];
   assign rd_re = rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign rd_im = rd_data[SAMPLE_BITS-1:0];
   assign abs_re = rd_re[SAMPLE_BITS-1] ? SAMPLE_BITS'(-rd_re) : rd_re;
   assign abs_im = rd_im[SAMPLE_BITS-1] ? SAMPLE_BITS'(-rd_im) : rd_im;
   assign idx_next = idx_ff + 1'b1;
   assign idx_last = (idx_next == job_ff.count);
   assign {rem_re_in, num_re_in} = div_step(rem_re_ff, num_re_ff, job_ff.peak);
   assign {rem_im_in, num_im_in} = div_step(rem_im_ff, num_im_ff, job_ff.peak);

   assign empty = !valid_ff;
   assign out_real = out_re_ff;
   assign out_imag = out_im_ff;
   assign end_of_trace = eot_ff;

   always_comb begin
      if (job_ff.kind == JOB_GAIN) begin
         res_re = sat_shift(gp_re_ff);
         res_im = cfg.complex_data ? sat_shift(gp_im_ff) : '0;
         res_eot = 1'b1;
      end else begin
         res_re = '0;
         res_im = '0;
         if (job_ff.peak != '0) begin
            res_re = sat_quot(num_re_ff, neg_re_ff);
            res_im = cfg.complex_data ? sat_quot(num_im_ff, neg_im_ff) : '0;
         end
         res_eot = idx_last;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      q_pop = 1'b0;
      load = 1'b0;
      trace_done = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               idx_in = '0;
               state_in = (q_job.kind == JOB_GAIN) ? B_GAIN : B_READ;
            end
         end
         B_GAIN: state_in = B_EMIT;
         B_READ: state_in = B_SCALE;
         B_SCALE: begin
            cnt_in = '0;
            state_in = B_DIVIDE;
         end
         B_DIVIDE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_BITS'(QUOT_BITS - 1)) begin
               state_in = B_EMIT;
            end
         end
         B_EMIT: begin
            if (!valid_ff || pop) begin
               load = 1'b1;
               if (job_ff.kind == JOB_GAIN) begin
                  state_in = B_IDLE;
               end else if (idx_last) begin
                  trace_done = 1'b1;
                  state_in = B_IDLE;
               end else begin
                  idx_in = idx_next;
                  state_in = B_READ;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
      valid_in = load ? 1'b1 : (pop ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      if (q_pop) begin
         job_ff <= q_job;
      end
      if (state_ff == B_GAIN) begin
         gp_re_ff <= PROD_BITS'(job_ff.re) * PROD_BITS'(cfg.gain);
         gp_im_ff <= PROD_BITS'(job_ff.im) * PROD_BITS'(cfg.gain);
      end
      if (state_ff == B_SCALE) begin
         num_re_ff <= QUOT_BITS'(abs_re) * QUOT_BITS'(FULL_SCALE);
         num_im_ff <= QUOT_BITS'(abs_im) * QUOT_BITS'(FULL_SCALE);
         neg_re_ff <= rd_re[SAMPLE_BITS-1];
         neg_im_ff <= rd_im[SAMPLE_BITS-1];
         rem_re_ff <= '0;
         rem_im_ff <= '0;
      end else if (state_ff == B_DIVIDE) begin
         num_re_ff <= num_re_in;
         num_im_ff <= num_im_in;
         rem_re_ff <= rem_re_in;
         rem_im_ff <= rem_im_in;
      end
      if (load) begin
         out_re_ff <= res_re;
         out_im_ff <= res_im;
         eot_ff <= res_eot;
      end
   end
endmodule

// File: hw/rtl/trace_peak_normalizer.sv
// top level of the trace peak normalizer with its register port
// In gain mode (or trace length 1) each word becomes a gain job in the job queue, and the
// front end keeps taking words while the back end works, until the queue is full.
// In normalize mode the front end finishes each word before it takes the next, a complex
// one by way of the bit-serial square root; once a trace is complete the back end reads
// it from the trace ram and divides each sample in turn with the bit-serial divider,
// and new words wait until the last result of that trace is loaded.
// A write to mode, trace_length or complex_data drops a partial trace.
`include "trace_peak_normalizer_macros.svh"
module trace_peak_normalizer
   import tpn_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_real,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_imag,
   output logic empty,
   input  logic pop,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_real,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_imag,
   output logic rsp_end_of_trace,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [3:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   logic mode_ff, cplx_ff;
   logic [LEN_BITS-1:0] len_ff;
   logic signed [GAIN_BITS-1:0] gain_ff;
   logic [1:0] reg_idx;
   logic cfg_wr, cfg_clear;
   cfg_type cfg;
   logic trace_busy_ff, trace_busy_in, trace_done;
   logic q_push, q_pop, q_empty, q_full;
   job_type q_job_in, q_job_out;
   logic wr_en;
   logic [ADDR_BITS-1:0] wr_addr, rd_addr;
   logic [2*SAMPLE_BITS-1:0] wr_data, rd_data;

   assign pready = 1'b1;
   assign reg_idx = paddr[3:2];
   assign cfg_wr = psel && penable && pwrite;
   assign cfg_clear = cfg_wr && (reg_idx == REG_MODE || reg_idx == REG_LENGTH ||
      reg_idx == REG_COMPLEX);

   always_comb begin
      cfg.complex_data = cplx_ff;
      cfg.gain = gain_ff;
      if (len_ff == '0) begin
         cfg.eff_len = LEN_BITS'(1);
      end else if (len_ff > LEN_BITS'(MAX_TRACE)) begin
         cfg.eff_len = LEN_BITS'(MAX_TRACE);
      end else begin
         cfg.eff_len = len_ff;
      end
      cfg.normalize = !mode_ff && (cfg.eff_len > LEN_BITS'(1));
   end

   always_comb begin
      case (reg_idx)
         REG_MODE: prdata = {31'd0, mode_ff};
         REG_LENGTH: prdata = {25'd0, len_ff};
         REG_GAIN: prdata = {16'd0, gain_ff};
         REG_COMPLEX: prdata = {31'd0, cplx_ff};
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         len_ff <= LEN_BITS'(MAX_TRACE);
         gain_ff <= GAIN_BITS'(256);
         cplx_ff <= 1'b0;
      end else if (cfg_wr) begin
         case (reg_idx)
            REG_MODE: mode_ff <= pwdata[0];
            REG_LENGTH: len_ff <= pwdata[LEN_BITS-1:0];
            REG_GAIN: gain_ff <= pwdata[GAIN_BITS-1:0];
            REG_COMPLEX: cplx_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   // the trace ram holds one trace, so the front waits while it drains
   always_comb begin
      trace_busy_in = trace_busy_ff;
      if (q_push && q_job_in.kind == JOB_TRACE) begin
         trace_busy_in = 1'b1;
      end else if (trace_done) begin
         trace_busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trace_busy_ff <= 1'b0;
      end else begin
         trace_busy_ff <= trace_busy_in;
      end
   end

   tpn_front u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .cfg_clear(cfg_clear),
      .push(push),
      .full(full),
      .sample_real(req_sample_real),
      .sample_imag(req_sample_imag),
      .q_full(q_full),
      .trace_busy(trace_busy_ff),
      .q_push(q_push),
      .q_job(q_job_in),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

   tpn_job_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .job_in(q_job_in),
      .pop(q_pop),
      .job_out(q_job_out),
      .empty(q_empty),
      .full(q_full)
   );

   tpn_ram #(
      .WIDTH(2 * SAMPLE_BITS),
      .DEPTH(MAX_TRACE)
   ) u_trace_ram (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   tpn_back u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .q_empty(q_empty),
      .q_job(q_job_out),
      .q_pop(q_pop),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .trace_done(trace_done),
      .pop(pop),
      .empty(empty),
      .out_real(rsp_out_real),
      .out_imag(rsp_out_imag),
      .end_of_trace(rsp_end_of_trace)
   );

   `TPN_ASSERT_IMPLY(trace_push_free_a, clock, reset, q_push && q_job_in.kind == JOB_TRACE, !trace_busy_ff)
   `TPN_ASSERT_IMPLY(trace_done_busy_a, clock, reset, trace_done, trace_busy_ff)
   `TPN_ASSERT_IMPLY(queue_no_overflow_a, clock, reset, q_push, !q_full)
   `TPN_ASSERT_NEXT(trace_done_result_a, clock, reset, trace_done, !empty && rsp_end_of_trace)
endmodule

// File: tb/trace_peak_normalizer_tb.sv
// testbench of the trace peak normalizer: directed and random traces checked against a predictor
`timescale 1ns / 1ps
module trace_peak_normalizer_tb;
   import tpn_pkg::*;

   typedef struct {
      logic signed [15:0] re;
      logic signed [15:0] im;
      logic eot;
   } word_type;

   typedef struct {
      logic signed [15:0] re;
      logic signed [15:0] im;
   } sample_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic signed [15:0] req_sample_real = '0;
   logic signed [15:0] req_sample_imag = '0;
   logic empty;
   logic pop = 1'b0;
   logic signed [15:0] rsp_out_real;
   logic signed [15:0] rsp_out_imag;
   logic rsp_end_of_trace;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [3:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   trace_peak_normalizer DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic cfg_mode;
   logic [6:0] cfg_len;
   logic signed [15:0] cfg_gain;
   logic cfg_complex;
   logic signed [15:0] buf_re [0:63];
   logic signed [15:0] buf_im [0:63];
   int unsigned peak;
   int unsigned fill;

   word_type expected_words [$];
   sample_word_type pending_samples [$];
   int errors = 0;
   int mismatches = 0;
   int hold_cycles = 0;
   logic driver_busy = 1'b0;

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
   endfunction

   function automatic longint gain_scale(longint s);
      longint p;
      p = s * longint'(cfg_gain);
      return p >>> 8;
   endfunction

   function automatic int unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return 32'(r);
   endfunction

   task automatic predict_sample(logic signed [15:0] sre, logic signed [15:0] sim);
      longint re, im;
      int unsigned len, mag;
      word_type w;
      re = longint'(sre);
      im = cfg_complex ? longint'(sim) : 0;
      len = (cfg_len == 0) ? 1 : (cfg_len > 64 ? 64 : cfg_len);
      if (cfg_mode || len <= 1) begin
         w.re = clamp16(gain_scale(re));
         w.im = cfg_complex ? clamp16(gain_scale(im)) : 16'sd0;
         w.eot = 1'b1;
         expected_words.push_back(w);
         return;
      end
      buf_re[fill] = sre;
      buf_im[fill] = cfg_complex ? sim : 16'sd0;
      mag = cfg_complex ? root_floor(re * re + im * im) : 32'(re < 0 ? -re : re);
      if (mag > peak) peak = mag;
      fill++;
      if (fill < len) return;
      for (int k = 0; k < fill; k++) begin
         w.re = '0;
         w.im = '0;
         if (peak > 0) begin
            w.re = clamp16((longint'(buf_re[k]) * 32767) / longint'(peak));
            if (cfg_complex) w.im = clamp16((longint'(buf_im[k]) * 32767) / longint'(peak));
         end
         w.eot = (k + 1 == fill);
         expected_words.push_back(w);
      end
      fill = 0;
      peak = 0;
   endtask

   // driver: predicts at the accepting edge
   int gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) begin
            predict_sample(req_sample_real, req_sample_imag);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
         end
         if (!push || !full) begin
            if (gap > 0) begin
               gap--;
               push <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               push <= 1'b1;
               req_sample_real <= pending_samples[0].re;
               req_sample_imag <= pending_samples[0].im;
               void'(pending_samples.pop_front());
            end else begin
               push <= 1'b0;
            end
         end
         driver_busy <= pending_samples.size() > 0 || (push && full) || gap > 0;
      end
   end

   // long receiver hold-off, counted down here
   always @(posedge clock) begin
      if (hold_cycles > 0) hold_cycles--;
   end

   // monitor and receiver stall
   int stall = 0;
   always @(posedge clock) begin
      word_type e;
      if (!reset) begin
         if (pop && !empty) begin
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected word %0d %0d %0b",
                  rsp_out_real, rsp_out_imag, rsp_end_of_trace);
            end else begin
               e = expected_words.pop_front();
               if (e.re !== rsp_out_real || e.im !== rsp_out_imag ||
                   e.eot !== rsp_end_of_trace) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp %0d %0d %0b got %0d %0d %0b", e.re, e.im,
                        e.eot, rsp_out_real, rsp_out_imag, rsp_end_of_trace);
               end
            end
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
         end
         if (hold_cycles > 0) begin
            pop <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_MODE: cfg_mode = value[0];
         REG_LENGTH: cfg_len = value[6:0];
         REG_GAIN: cfg_gain = value[15:0];
         default: cfg_complex = value[0];
      endcase
      if (idx != REG_GAIN) begin
         fill = 0;
         peak = 0;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic drain();
      do @(posedge clock);
      while (driver_busy || push || pending_samples.size() > 0 || expected_words.size() > 0);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sd0;
         3: return 16'($urandom_range(0, 15)) - 16'sd8;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_sample(logic signed [15:0] re, logic signed [15:0] im);
      sample_word_type s;
      s.re = re;
      s.im = im;
      pending_samples.push_back(s);
   endtask

   task automatic queue_traces(int count, int unsigned len);
      for (int i = 0; i < count * len; i++) queue_sample(rand_sample(), rand_sample());
   endtask

   initial begin
      cfg_mode = 1'b0;
      cfg_len = 7'd64;
      cfg_gain = 16'sd256;
      cfg_complex = 1'b0;
      fill = 0;
      peak = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: gain extremes, real and complex
      write_reg(REG_MODE, 1);
      write_reg(REG_GAIN, 32'h0000_7fff);
      queue_sample(16'sh7fff, 16'sh8000);
      queue_sample(16'sh8000, 16'sh7fff);
      queue_sample(-16'sd1, 16'sd1);
      drain();
      write_reg(REG_COMPLEX, 1);
      write_reg(REG_GAIN, 32'h0000_8000);
      queue_sample(16'sh7fff, 16'sh8000);
      queue_sample(-16'sd3, 16'sd5);
      drain();
      // zero length acts as gain mode, length above 64 saturates
      write_reg(REG_MODE, 0);
      write_reg(REG_LENGTH, 0);
      queue_sample(16'sd100, -16'sd100);
      drain();
      write_reg(REG_LENGTH, 32'h7f);
      write_reg(REG_COMPLEX, 0);
      queue_traces(1, 64);
      drain();
      // all-zero trace, then extremes in a short complex trace
      write_reg(REG_LENGTH, 4);
      repeat (4) queue_sample(16'sd0, 16'sh7fff);
      drain();
      write_reg(REG_COMPLEX, 1);
      queue_sample(16'sh8000, 16'sh8000);
      queue_sample(16'sh7fff, 16'sh7fff);
      queue_sample(16'sd1, -16'sd1);
      queue_sample(16'sd0, 16'sd0);
      drain();
      // partial trace dropped by a length write; gain write keeps it
      write_reg(REG_LENGTH, 3);
      queue_sample(16'sd7, 16'sd9);
      drain();
      write_reg(REG_LENGTH, 2);
      queue_sample(16'sd40, -16'sd3);
      drain();
      write_reg(REG_GAIN, 32'h100);
      queue_sample(-16'sd2, 16'sd11);
      drain();

      // long receiver hold-off while the sender keeps offering words
      write_reg(REG_MODE, 1);
      hold_cycles = 600;
      for (int i = 0; i < 40; i++) queue_sample(rand_sample(), rand_sample());
      drain();

      // random phases
      for (int phase = 0; phase < 7; phase++) begin
         int unsigned len;
         write_reg(REG_MODE, 32'(phase % 3 == 2));
         write_reg(REG_COMPLEX, $urandom_range(0, 1));
         write_reg(REG_GAIN, $urandom);
         len = (phase == 4) ? 64 : $urandom_range(1, 8);
         write_reg(REG_LENGTH, len);
         queue_traces((phase == 4) ? 1 : 32 / len, len);
         drain();
      end

      if (mismatches == 0 && errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end
endmodule
